@@ sv/wsb_pkg.sv @@
// Package: shared constants, codes and control types of the wheel speed balancer.
package wsb_pkg;

  localparam int unsigned ERR_BITS      = 16;
  localparam int unsigned RATIO_BITS    = 16;
  localparam int unsigned ONE_BITS      = ERR_BITS + 1;
  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned DIV_CNT_BITS  = $clog2(RATIO_BITS);

  localparam logic [ONE_BITS-1:0] ERR_ONE      = ONE_BITS'(1) << ERR_BITS;
  localparam logic [ERR_BITS-1:0] ERR_MAX      = '1;
  localparam logic [ERR_BITS-1:0] MIN_ERR_RST  = 16'd655;
  localparam logic [ERR_BITS-1:0] START_ERR    = 16'd3277;
  localparam int unsigned         MAX_RATE_RST = 255;
  localparam int unsigned         START_RATE   = 200;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_RATE    = 4'd0,
    CFG_MIN_ERROR   = 4'd1,
    CFG_START_ERROR = 4'd2,
    CFG_START_RATE  = 4'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_SHRINK,
    MUL_GROW,
    MUL_RATIO,
    MUL_SCALE
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHRINK_MUL,
    ST_SHRINK_WB,
    ST_DIVIDE,
    ST_RATIO_MUL,
    ST_SCALE_MUL,
    ST_SCALE_WB,
    ST_GROW_MUL,
    ST_GROW_WB,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     err_shrink;
    logic     err_grow;
    logic     div_step;
    logic     rate_wb;
    logic     out_load;
  } wsb_cmd_t;

  typedef struct packed {
    logic both_zero;
    logic equal;
  } wsb_stat_t;

endpackage

@@ sv/wsb_if.sv @@
// Interfaces: speed input, drive output and configuration write channels.
interface wsb_in_if #(
  parameter int unsigned SPEED_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [SPEED_BITS-1:0] left_speed;
  logic [SPEED_BITS-1:0] right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

interface wsb_out_if #(
  parameter int unsigned RATE_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [RATE_BITS-1:0] left_drive;
  logic [RATE_BITS-1:0] right_drive;
  logic                 updated;
  logic [15:0]          error_factor;

  modport source (output valid, output left_drive, output right_drive, output updated,
                  output error_factor, input ready);
  modport sink   (input valid, input left_drive, input right_drive, input updated,
                  input error_factor, output ready);
endinterface

interface wsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/wheel_speed_balancer_core.sv @@
// Top level: wheel speed balancer, controller plus datapath behind handshake channels.
// Sequence: accept, then decide; both speeds zero go straight to the output register, equal
//   speeds grow the error, unequal speeds shrink it, run the restoring divider and scale.
// Flow: one speed pair at a time; the next is taken in the cycle after the result
//   enters the output register, and a stalled output register can hold the finished
//   pair back before that.
// Reset: asynchronous, active low; state and config registers reset, error 3277, rates 200.
module wheel_speed_balancer_core #(
  parameter int unsigned SPEED_BITS = 16,
  parameter int unsigned RATE_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wsb_in_if.sink    speed_i,
  wsb_out_if.source drive_o,
  wsb_cfg_if.sink   cfg_i
);
  import wsb_pkg::*;

  wsb_cmd_t  cmd;
  wsb_stat_t stat;
  logic      cfg_we;

  // config ready is tied high, so the write channel never stalls
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  // Controller: accept one pair in idle, walk the multiply/divide steps,
  // then hand the result to the output register when it is free.
  wsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (speed_i.valid),
    .in_ready_o  (speed_i.ready),
    .out_valid_o (drive_o.valid),
    .out_ready_i (drive_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: one shared multiplier serves the error update (e*(1-e) or e*e),
  // the max_rate*ratio product and the final scale by (1-e); the speed ratio
  // comes from a one-bit-per-cycle restoring divider.
  wsb_dp #(
    .SPEED_BITS (SPEED_BITS),
    .RATE_BITS  (RATE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .left_speed_i   (speed_i.left_speed),
    .right_speed_i  (speed_i.right_speed),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .left_drive_o   (drive_o.left_drive),
    .right_drive_o  (drive_o.right_drive),
    .updated_o      (drive_o.updated),
    .error_factor_o (drive_o.error_factor)
  );

endmodule

@@ sv/wsb_ctrl.sv @@
// Controller: sequences multiply, divide and write-back steps of one speed pair.
module wsb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wsb_pkg::wsb_stat_t stat_i,
  output wsb_pkg::wsb_cmd_t  cmd_o
);
  import wsb_pkg::*;

  state_e                  state_q, state_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_SHRINK;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cnt_d = '0;
        priority if (stat_i.both_zero) state_d = ST_FINISH;
        else if (stat_i.equal)         state_d = ST_GROW_MUL;
        else                           state_d = ST_SHRINK_MUL;
      end
      ST_SHRINK_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SHRINK;
        state_d       = ST_SHRINK_WB;
      end
      ST_SHRINK_WB: begin
        cmd_o.err_shrink = 1'b1;
        state_d          = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_BITS'(RATIO_BITS - 1)) state_d = ST_RATIO_MUL;
      end
      ST_RATIO_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RATIO;
        state_d       = ST_SCALE_MUL;
      end
      ST_SCALE_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SCALE;
        state_d       = ST_SCALE_WB;
      end
      ST_SCALE_WB: begin
        cmd_o.rate_wb = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_GROW_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GROW;
        state_d       = ST_GROW_WB;
      end
      ST_GROW_WB: begin
        cmd_o.err_grow = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/wsb_dp.sv @@
// Datapath: config registers, balancer state, shared multiplier and ratio divider.
module wsb_dp #(
  parameter int unsigned SPEED_BITS = 16,
  parameter int unsigned RATE_BITS  = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wsb_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [wsb_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic [SPEED_BITS-1:0]              left_speed_i,
  input  logic [SPEED_BITS-1:0]              right_speed_i,
  input  wsb_pkg::wsb_cmd_t                  cmd_i,
  output wsb_pkg::wsb_stat_t                 stat_o,
  output logic [RATE_BITS-1:0]               left_drive_o,
  output logic [RATE_BITS-1:0]               right_drive_o,
  output logic                               updated_o,
  output logic [wsb_pkg::ERR_BITS-1:0]       error_factor_o
);
  import wsb_pkg::*;

  localparam int unsigned MA = RATE_BITS + RATIO_BITS;
  localparam int unsigned MB = ONE_BITS;
  localparam int unsigned MP = MA + MB;

  // configuration; start values are fixed constants used at reset, writes to them are ignored
  logic [RATE_BITS-1:0]    max_rate_q;
  logic [ERR_BITS-1:0]     min_error_q;

  // balancer state
  logic [ERR_BITS-1:0]     err_q, err_d;
  logic [RATE_BITS-1:0]    left_rate_q, right_rate_q;

  // per-item working registers
  logic                    zero_q, equal_q, left_gt_q;
  logic [SPEED_BITS-1:0]   fast_q;
  logic [SPEED_BITS:0]     rem_q;
  logic [RATIO_BITS-1:0]   quo_q;
  logic [MP-1:0]           prod_q;

  // output register
  logic [RATE_BITS-1:0]    left_out_q, right_out_q;
  logic                    upd_out_q;
  logic [ERR_BITS-1:0]     err_out_q;

  logic [MA-1:0]           mul_a;
  logic [MB-1:0]           mul_b;
  logic [MB-1:0]           one_minus_err;
  logic [SPEED_BITS:0]     rem_shift;
  logic                    rem_ge;
  logic [ERR_BITS-1:0]     prod_hi;
  logic [ERR_BITS:0]       grow_sum;
  logic [RATE_BITS-1:0]    scaled;
  logic                    in_left_gt;

  assign one_minus_err = ERR_ONE - {1'b0, err_q};
  assign prod_hi       = prod_q[ERR_BITS +: ERR_BITS];
  assign grow_sum      = {1'b0, err_q} + {1'b0, prod_hi};
  assign scaled        = prod_q[2*ERR_BITS +: RATE_BITS];
  assign rem_shift     = {rem_q[SPEED_BITS-1:0], 1'b0};
  assign rem_ge        = rem_shift >= {1'b0, fast_q};
  assign in_left_gt    = left_speed_i > right_speed_i;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SHRINK: begin
        mul_a = MA'(err_q);
        mul_b = one_minus_err;
      end
      MUL_GROW: begin
        mul_a = MA'(err_q);
        mul_b = MB'(err_q);
      end
      MUL_RATIO: begin
        mul_a = MA'(max_rate_q);
        mul_b = MB'(quo_q);
      end
      MUL_SCALE: begin
        mul_a = prod_q[MA-1:0];
        mul_b = one_minus_err;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    err_d = err_q;
    priority if (cmd_i.err_shrink) begin
      err_d = (prod_hi < min_error_q) ? min_error_q : prod_hi;
    end else if (cmd_i.err_grow) begin
      err_d = grow_sum[ERR_BITS] ? ERR_MAX : grow_sum[ERR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q   <= RATE_BITS'(MAX_RATE_RST);
      min_error_q  <= MIN_ERR_RST;
      err_q        <= START_ERR;
      left_rate_q  <= RATE_BITS'(START_RATE);
      right_rate_q <= RATE_BITS'(START_RATE);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_RATE:  max_rate_q  <= cfg_data_i[RATE_BITS-1:0];
          CFG_MIN_ERROR: min_error_q <= cfg_data_i[ERR_BITS-1:0];
          default: ;
        endcase
      end
      err_q <= err_d;
      if (cmd_i.rate_wb) begin
        if (left_gt_q) begin
          left_rate_q  <= scaled;
          right_rate_q <= max_rate_q;
        end else begin
          left_rate_q  <= max_rate_q;
          right_rate_q <= scaled;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      zero_q    <= (left_speed_i == '0) && (right_speed_i == '0);
      equal_q   <= left_speed_i == right_speed_i;
      left_gt_q <= in_left_gt;
      fast_q    <= in_left_gt ? left_speed_i : right_speed_i;
      rem_q     <= {1'b0, in_left_gt ? right_speed_i : left_speed_i};
      quo_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_shift - {1'b0, fast_q} : rem_shift;
      quo_q <= {quo_q[RATIO_BITS-2:0], rem_ge};
    end
    if (cmd_i.mul_en) begin
      prod_q <= MP'(mul_a) * MP'(mul_b);
    end
    if (cmd_i.out_load) begin
      left_out_q  <= left_rate_q;
      right_out_q <= right_rate_q;
      upd_out_q   <= !zero_q;
      err_out_q   <= err_q;
    end
  end

  assign stat_o.both_zero = zero_q;
  assign stat_o.equal     = equal_q;
  assign left_drive_o     = left_out_q;
  assign right_drive_o    = right_out_q;
  assign updated_o        = upd_out_q;
  assign error_factor_o   = err_out_q;

endmodule

@@ tb/testbench.sv @@
// Testbench: random and directed speed pairs against a predictor of the wheel speed balancer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wsb_pkg::*;

  localparam int unsigned SPEED_BITS  = 16;
  localparam int unsigned RATE_BITS   = 8;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 4000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int unsigned HOLD_CYCLES = 400;
  // Cycles to wait after the last result, well past the slowest latency.
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned ITEMS_PER_PHASE = 272;
  localparam int unsigned NO_HOLD = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [RATE_BITS-1:0] left_drive;
    logic [RATE_BITS-1:0] right_drive;
    logic                 updated;
    logic [ERR_BITS-1:0]  error_factor;
  } drive_t;

  // Predicts the drive rates and error factor per speed pair and checks them in order.
  class drive_scoreboard;
    logic [RATE_BITS-1:0] max_rate;
    logic [ERR_BITS-1:0]  min_error;
    logic [ERR_BITS-1:0]  start_error;
    logic [RATE_BITS-1:0] start_rate;
    logic [ERR_BITS-1:0]  error_level;
    logic [RATE_BITS-1:0] left_rate;
    logic [RATE_BITS-1:0] right_rate;
    drive_t               expected_drives[$];
    int unsigned          mismatches;

    function void load_reset();
      max_rate    = RATE_BITS'(MAX_RATE_RST);
      min_error   = MIN_ERR_RST;
      start_error = START_ERR;
      start_rate  = RATE_BITS'(START_RATE);
      error_level = start_error;
      left_rate   = start_rate;
      right_rate  = start_rate;
      mismatches  = 0;
      expected_drives.delete();
    endfunction

    // Start values only take effect at reset, so a write just stores them.
    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_MAX_RATE:    max_rate    = data[RATE_BITS-1:0];
        CFG_MIN_ERROR:   min_error   = data[ERR_BITS-1:0];
        CFG_START_ERROR: start_error = data[ERR_BITS-1:0];
        CFG_START_RATE:  start_rate  = data[RATE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [ERR_BITS-1:0] shrunk_error(logic [ERR_BITS-1:0] e);
      logic [63:0] n;
      n = (64'(e) * (64'(ERR_ONE) - 64'(e))) >> ERR_BITS;
      if (n < 64'(min_error)) n = 64'(min_error);
      return n[ERR_BITS-1:0];
    endfunction

    function logic [RATE_BITS-1:0] scaled_rate(logic [SPEED_BITS-1:0] slow,
                                               logic [SPEED_BITS-1:0] fast,
                                               logic [ERR_BITS-1:0] e);
      logic [63:0] ratio;
      logic [63:0] prod;
      ratio = (64'(slow) << RATIO_BITS) / 64'(fast);
      prod  = (64'(max_rate) * ratio * (64'(ERR_ONE) - 64'(e))) >> (RATIO_BITS + ERR_BITS);
      return prod[RATE_BITS-1:0];
    endfunction

    function void note_speeds(logic [SPEED_BITS-1:0] ls, logic [SPEED_BITS-1:0] rs);
      drive_t      predicted;
      logic        updated;
      logic [63:0] grown;
      updated = 1'b0;
      if (ls != 0 || rs != 0) begin
        updated = 1'b1;
        if (ls > rs) begin
          error_level = shrunk_error(error_level);
          right_rate  = max_rate;
          left_rate   = scaled_rate(rs, ls, error_level);
        end else if (ls < rs) begin
          error_level = shrunk_error(error_level);
          left_rate   = max_rate;
          right_rate  = scaled_rate(ls, rs, error_level);
        end else begin
          grown = 64'(error_level) + ((64'(error_level) * 64'(error_level)) >> ERR_BITS);
          if (grown > 64'(ERR_MAX)) grown = 64'(ERR_MAX);
          error_level = grown[ERR_BITS-1:0];
        end
      end
      predicted.left_drive   = left_rate;
      predicted.right_drive  = right_rate;
      predicted.updated      = updated;
      predicted.error_factor = error_level;
      expected_drives.push_back(predicted);
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: left %0d right %0d upd %0b err %0d",
                   $realtime, got.left_drive, got.right_drive, got.updated, got.error_factor);
        return;
      end
      want = expected_drives.pop_front();
      if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
          got.updated !== want.updated || got.error_factor !== want.error_factor) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: want %0d/%0d/%0b/%0d, got %0d/%0d/%0b/%0d",
                   $realtime, want.left_drive, want.right_drive, want.updated,
                   want.error_factor, got.left_drive, got.right_drive, got.updated,
                   got.error_factor);
      end
    endfunction

    function int unsigned pending();
      return expected_drives.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  wsb_in_if  #(.SPEED_BITS(SPEED_BITS)) speed_if ();
  wsb_out_if #(.RATE_BITS(RATE_BITS))   drive_if ();
  wsb_cfg_if                            cfg_if ();

  wheel_speed_balancer_core #(
    .SPEED_BITS(SPEED_BITS),
    .RATE_BITS (RATE_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .speed_i(speed_if.sink),
    .drive_o(drive_if.source),
    .cfg_i  (cfg_if.sink)
  );

  drive_scoreboard scoreboard;

  // Sender and receiver pacing, set per phase by the stimulus process.
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned stall_pct;
  logic        hold_req;

  // Free-running clock, 20 ns period.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Lower valid for a random gap at the end of a burst (if gaps are enabled), then offer the next
  // pair and hold it until the block takes it. Valid stays high across back-to-back pairs.
  task automatic send_speeds(input logic [SPEED_BITS-1:0] ls,
                             input logic [SPEED_BITS-1:0] rs);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        speed_if.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    speed_if.valid       <= 1'b1;
    speed_if.left_speed  <= ls;
    speed_if.right_speed <= rs;
    do @(posedge clk_i); while (!speed_if.ready);
    scoreboard.note_speeds(ls, rs);
    burst_left--;
  endtask

  // Close the current burst; the block goes idle once its result enters the output register.
  task automatic end_burst();
    speed_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait until every predicted result has been checked.
  task automatic drain();
    while (scoreboard.pending() != 0) @(posedge clk_i);
  endtask

  // Offer one register write and hold it until accepted; the caller lowers valid.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    scoreboard.write_reg(idx, data);
  endtask

  // Write all registers plus one unmapped index. Upper data bits of the rate registers are
  // random so that masking gets exercised.
  task automatic configure(input logic [RATE_BITS-1:0] rate,
                           input logic [ERR_BITS-1:0] min_err);
    logic [CFG_IDX_BITS-1:0] unmapped;
    unmapped = CFG_IDX_BITS'(CFG_START_RATE) + CFG_IDX_BITS'($urandom_range(1, 12));
    write_reg(CFG_MAX_RATE, {8'($urandom), rate});
    write_reg(unmapped, 16'($urandom));
    write_reg(CFG_MIN_ERROR, min_err);
    write_reg(CFG_START_ERROR, 16'($urandom));
    write_reg(CFG_START_RATE, 16'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  // Mix of equal, zero, near-equal, tiny and full-range pairs so the error factor both
  // grows toward saturation and shrinks toward its clamp.
  function automatic void pick_speeds(output logic [SPEED_BITS-1:0] ls,
                                      output logic [SPEED_BITS-1:0] rs);
    logic [SPEED_BITS-1:0] base;
    base = SPEED_BITS'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        ls = '0;
        rs = '0;
      end
      1, 2: begin
        ls = ($urandom_range(0, 1) != 0) ? base : SPEED_BITS'($urandom_range(1, 255));
        rs = ls;
      end
      3: begin
        if ($urandom_range(0, 1) != 0) begin
          ls = base;
          rs = '0;
        end else begin
          ls = '0;
          rs = base;
        end
      end
      4: begin
        ls = base;
        rs = base + SPEED_BITS'($urandom_range(0, 8)) - SPEED_BITS'(4);
      end
      5: begin
        ls = SPEED_BITS'($urandom_range(0, 15));
        rs = SPEED_BITS'($urandom_range(0, 15));
      end
      default: begin
        ls = base;
        rs = SPEED_BITS'($urandom);
      end
    endcase
  endfunction

  task automatic run_phase(input int unsigned items, input int unsigned hold_at);
    logic [SPEED_BITS-1:0] ls;
    logic [SPEED_BITS-1:0] rs;
    for (int unsigned n = 0; n < items; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      pick_speeds(ls, rs);
      send_speeds(ls, rs);
    end
    end_burst();
  endtask

  // Speed extremes under the reset configuration: both zero, equal, one side zero,
  // neighbors at full scale and swapped halves.
  task automatic run_directed();
    logic [2*SPEED_BITS-1:0] pairs [$];
    pairs = '{32'h0000_0000, 32'h0064_0064, 32'hFFFF_FFFF, 32'hFFFF_0000,
              32'h0000_FFFF, 32'hFFFF_FFFE, 32'hFFFE_FFFF, 32'h0001_0000,
              32'h0000_0001, 32'h8000_4000, 32'h4000_8000, 32'h5555_AAAA,
              32'hAAAA_5555, 32'h0001_0001, 32'h0000_0000, 32'h0001_FFFF,
              32'hFFFF_0001, 32'h7FFF_8000, 32'h8000_7FFF, 32'h0000_0000};
    foreach (pairs[i]) send_speeds(pairs[i][2*SPEED_BITS-1:SPEED_BITS],
                                   pairs[i][SPEED_BITS-1:0]);
    end_burst();
  endtask

  task automatic set_pacing(input int unsigned gap, input int unsigned stall);
    gap_max   = gap;
    stall_pct = stall;
  endtask

  // Main stimulus: directed pairs, then random phases under several settings.
  initial begin
    speed_if.valid       = 1'b0;
    speed_if.left_speed  = '0;
    speed_if.right_speed = '0;
    drive_if.ready       = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    burst_left           = 0;
    gap_max              = 0;
    stall_pct            = 0;
    hold_req             = 1'b0;
    rst_ni               = 1'b0;
    scoreboard = new;
    scoreboard.load_reset();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration first, light idling.
    set_pacing(3, 20);
    run_directed();
    drain();

    // Full drive, no clamp, no idling at all.
    configure(8'd255, 16'd0);
    set_pacing(0, 0);
    run_phase(ITEMS_PER_PHASE, NO_HOLD);
    drain();

    // Zero drive, clamp at the top so the error factor pins near one.
    configure(8'd0, 16'hFFFF);
    set_pacing($urandom_range(1, 12), $urandom_range(5, 60));
    run_phase(ITEMS_PER_PHASE, NO_HOLD);
    drain();

    // Minimal drive, reset clamp; back the block up with a long hold-off.
    configure(8'd1, MIN_ERR_RST);
    set_pacing($urandom_range(0, 4), $urandom_range(5, 30));
    run_phase(ITEMS_PER_PHASE, 40);
    drain();

    configure(8'($urandom), 16'($urandom_range(0, 2000)));
    set_pacing($urandom_range(1, 12), $urandom_range(5, 60));
    run_phase(ITEMS_PER_PHASE, NO_HOLD);
    drain();

    configure(8'($urandom), 16'($urandom));
    set_pacing($urandom_range(1, 6), $urandom_range(30, 80));
    run_phase(ITEMS_PER_PHASE, NO_HOLD);
    drain();

    configure(8'd255, 16'($urandom_range(0, 20000)));
    set_pacing($urandom_range(1, 12), $urandom_range(0, 40));
    run_phase(ITEMS_PER_PHASE, NO_HOLD);
    drain();

    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random stall runs, plus a long hold-off when the stimulus asks for one.
  initial begin : drive_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        drive_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        drive_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 11);
        drive_if.ready <= 1'b0;
      end else begin
        drive_if.ready <= 1'b1;
      end
    end
  end

  // Check every accepted result transaction against the oldest prediction.
  always @(posedge clk_i) begin : drive_check
    drive_t got;
    if (rst_ni && drive_if.valid && drive_if.ready) begin
      got.left_drive   = drive_if.left_drive;
      got.right_drive  = drive_if.right_drive;
      got.updated      = drive_if.updated;
      got.error_factor = drive_if.error_factor;
      scoreboard.check_drive(got);
    end
  end

  // Watchdog: end the run if no transaction moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((speed_if.valid && speed_if.ready) || (drive_if.valid && drive_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
